// ----- design/euler_dcm_dead_reckoning_step_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Euler DCM dead-reckoning block
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EULER_DCM_DEAD_RECKONING_STEP_MACROS_SVH
`define EULER_DCM_DEAD_RECKONING_STEP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define EDR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("EDR check failed");
// Next-cycle implication.
`define EDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("EDR check failed");
`else
`define EDR_ASSERT_IMPL(lbl, ante, cons)
`define EDR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/edr_pkg.sv -----
// ----------------------------------------------------------------------------
// edr_pkg
// Types, constants and table helpers shared by the dead-reckoning block.
// ----------------------------------------------------------------------------
package edr_pkg;

  // Table size default and fixed-point constants.
  localparam int unsigned SineEntriesDef = 1024;
  localparam longint unsigned PiHalfQ30 = 64'd1686629713;
  localparam longint unsigned InvTwoPiQ32 = 64'd683565276;
  localparam logic [15:0] StepTimeReset = 16'd6554;

  // Field widths.
  localparam int unsigned AngW  = 16;
  localparam int unsigned AcclW = 16;
  localparam int unsigned DtW   = 16;
  localparam int unsigned SinW  = 17;
  localparam int unsigned TrigW = 18;
  localparam int unsigned MatW  = 19;
  localparam int unsigned VelW  = 32;
  localparam int unsigned PosW  = 48;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [MatW-1:0]  mat_t;
  typedef mat_t [2:0]              mat_row_t;
  typedef logic signed [VelW-1:0]  vel_t;
  typedef vel_t [2:0]              vel_vec_t;
  typedef logic signed [PosW-1:0]  pos_t;

  // Sine and cosine of one angle.
  typedef struct packed {
    trig_t sin_val;
    trig_t cos_val;
  } sincos_t;

  typedef struct packed {
    logic signed [AngW-1:0]  roll_angle;
    logic signed [AngW-1:0]  pitch_angle;
    logic signed [AngW-1:0]  yaw_angle;
    logic signed [AcclW-1:0] accel_x;
    logic signed [AcclW-1:0] accel_y;
    logic signed [AcclW-1:0] accel_z;
  } in_beat_t;

  typedef struct packed {
    vel_t earth_vel_x;
    vel_t earth_vel_y;
    vel_t earth_vel_z;
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_DCM,
    ST_ROWS,
    ST_DONE
  } edr_state_e;

  // Quarter-wave sine entry in Q16 from a Q30 phase, Taylor series to x^15.
  // Only evaluated at elaboration to build the table.
  function automatic logic [SinW-1:0] quarter_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 64'sd8192) >>> 14;
    if (r > 64'sd65536) begin
      r = 64'sd65536;
    end
    return SinW'(r);
  endfunction

endpackage

// ----- design/edr_in_if.sv -----
// ----------------------------------------------------------------------------
// edr_in_if
// Valid/ready channel carrying one sample beat into the block.
// ----------------------------------------------------------------------------
interface edr_in_if;
  import edr_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/edr_out_if.sv -----
// ----------------------------------------------------------------------------
// edr_out_if
// Valid/ready channel carrying one result beat out of the block.
// ----------------------------------------------------------------------------
interface edr_out_if;
  import edr_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/edr_trig_lane.sv -----
// ----------------------------------------------------------------------------
// edr_trig_lane
// One angle lane: maps the angle to a table phase and reads sine and cosine
// from a quarter-wave ROM, one ROM read per cycle.
// ----------------------------------------------------------------------------
module edr_trig_lane #(
  parameter int unsigned SINE_TABLE_ENTRIES = edr_pkg::SineEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [edr_pkg::AngW-1:0] angle_i,
  output logic                           done_o,
  output edr_pkg::sincos_t               sc_o
);
  import edr_pkg::*;

  localparam int unsigned N    = SINE_TABLE_ENTRIES;
  localparam int unsigned N4   = 4 * N;
  localparam int unsigned PhW  = $clog2(5 * N);
  localparam int unsigned AdW  = $clog2(N + 1);
  localparam longint unsigned PhaseK = InvTwoPiQ32 * 64'(N4);
  localparam int unsigned KW   = $clog2(PhaseK + 1);
  localparam int unsigned PrW  = KW + AngW + 1;
  localparam int unsigned RndSh = 45;
  localparam logic [PrW:0] RndHalf = (PrW + 1)'(1) << (RndSh - 1);

  // Sequence steps.
  localparam logic [2:0] StepMul     = 3'd0;
  localparam logic [2:0] StepPhase   = 3'd1;
  localparam logic [2:0] StepSinAddr = 3'd2;
  localparam logic [2:0] StepSinData = 3'd3;
  localparam logic [2:0] StepCosData = 3'd4;

  logic [SinW-1:0] rom [N+1];
  logic [SinW-1:0] rom_q;

  logic                   busy_q;
  logic                   done_q;
  logic [2:0]             cnt_q;
  logic signed [AngW-1:0] ang_q;
  logic [PrW-1:0]         p_q;
  logic [PhW-1:0]         ph_q;
  logic                   neg_q;
  trig_t                  sin_q;
  trig_t                  cos_q;

  logic signed [AngW:0] ang_x;
  logic [AngW:0]        mag_c;
  logic [PrW:0]         psum_c;
  logic [PhW-1:0]       ph_red;
  logic [PhW-1:0]       rem_c;
  logic [1:0]           quad_c;
  logic [AdW-1:0]       addr_c;
  trig_t                entry_c;

  // Quarter-wave table, filled with constants at elaboration.
  for (genvar k = 0; k <= N; k++) begin : g_rom
    localparam longint unsigned X = (64'(k) * PiHalfQ30 + 64'(N / 2)) / 64'(N);
    assign rom[k] = quarter_sine(X);
  end

  // Angle magnitude and rounded table phase.
  always_comb begin
    ang_x  = {ang_q[AngW-1], ang_q};
    mag_c  = ang_x[AngW] ? unsigned'(-ang_x) : unsigned'(ang_x);
    psum_c = {1'b0, p_q} + RndHalf;
  end

  // Phase to quadrant, table address and sign.
  always_comb begin
    ph_red = ph_q;
    if (ph_q >= PhW'(N4)) begin
      ph_red = ph_q - PhW'(N4);
    end
    priority if (ph_red < PhW'(N)) begin
      quad_c = 2'd0;
      rem_c  = ph_red;
    end else if (ph_red < PhW'(2 * N)) begin
      quad_c = 2'd1;
      rem_c  = ph_red - PhW'(N);
    end else if (ph_red < PhW'(3 * N)) begin
      quad_c = 2'd2;
      rem_c  = ph_red - PhW'(2 * N);
    end else begin
      quad_c = 2'd3;
      rem_c  = ph_red - PhW'(3 * N);
    end
    addr_c  = quad_c[0] ? AdW'(PhW'(N) - rem_c) : AdW'(rem_c);
    entry_c = trig_t'({1'b0, rom_q});
  end

  // Registered ROM read.
  always_ff @(posedge clk_i) begin
    rom_q <= rom[addr_c];
  end

  // Sequencer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= StepMul;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StepMul;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == StepCosData) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath steps.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ang_q <= angle_i;
    end else if (busy_q) begin
      unique case (cnt_q)
        StepMul: begin
          p_q <= PrW'(mag_c) * PrW'(PhaseK);
        end
        StepPhase: begin
          ph_q <= PhW'(psum_c >> RndSh);
        end
        StepSinAddr: begin
          neg_q <= quad_c[1];
          ph_q  <= ph_q + PhW'(N);
        end
        StepSinData: begin
          sin_q <= (neg_q ^ ang_q[AngW-1]) ? -entry_c : entry_c;
          neg_q <= quad_c[1];
        end
        StepCosData: begin
          cos_q <= neg_q ? -entry_c : entry_c;
        end
        default: begin
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign sc_o   = '{sin_val: sin_q, cos_val: cos_q};

endmodule

// ----- design/edr_dcm.sv -----
// ----------------------------------------------------------------------------
// edr_dcm
// Merges the three angle lanes into the direction cosine matrix. The fourteen
// Q16 products go through one shared multiplier, one per cycle, and a final
// step forms the sums and differences.
// ----------------------------------------------------------------------------
module edr_dcm (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  edr_pkg::sincos_t [2:0] sc_i,
  output logic                   done_o,
  output edr_pkg::mat_row_t [2:0] mat_o
);
  import edr_pkg::*;

  localparam int unsigned NumProd = 14;
  localparam int unsigned StW     = $clog2(NumProd + 1);
  localparam int unsigned IdxW    = $clog2(NumProd);
  localparam int unsigned MulW    = 2 * TrigW;
  localparam logic signed [MulW-1:0] MulHalf = MulW'(32768);

  trig_t s1, c1, s2, c2, s3, c3;

  logic             busy_q;
  logic             done_q;
  logic [StW-1:0]   step_q;
  trig_t            prod_q [NumProd];
  mat_t             m01_q, m02_q, m11_q, m12_q;

  trig_t                  op_a;
  trig_t                  op_b;
  logic signed [MulW-1:0] mul_c;
  trig_t                  prod_c;

  always_comb begin
    s1 = sc_i[0].sin_val;
    c1 = sc_i[0].cos_val;
    s2 = sc_i[1].sin_val;
    c2 = sc_i[1].cos_val;
    s3 = sc_i[2].sin_val;
    c3 = sc_i[2].cos_val;
  end

  // Operand selection for each product of the sequence.
  always_comb begin
    unique case (step_q)
      4'd0:    begin op_a = s1;        op_b = s2; end
      4'd1:    begin op_a = c1;        op_b = s2; end
      4'd2:    begin op_a = c2;        op_b = c3; end
      4'd3:    begin op_a = prod_q[0]; op_b = c3; end
      4'd4:    begin op_a = c1;        op_b = s3; end
      4'd5:    begin op_a = prod_q[1]; op_b = c3; end
      4'd6:    begin op_a = s1;        op_b = s3; end
      4'd7:    begin op_a = c2;        op_b = s3; end
      4'd8:    begin op_a = prod_q[0]; op_b = s3; end
      4'd9:    begin op_a = c1;        op_b = c3; end
      4'd10:   begin op_a = prod_q[1]; op_b = s3; end
      4'd11:   begin op_a = s1;        op_b = c3; end
      4'd12:   begin op_a = s1;        op_b = c2; end
      4'd13:   begin op_a = c1;        op_b = c2; end
      default: begin op_a = '0;        op_b = '0; end
    endcase
    mul_c  = op_a * op_b;
    prod_c = trig_t'((mul_c + MulHalf) >>> 16);
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StW'(1);
        if (step_q == StW'(NumProd)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Products, then the combined entries on the last step.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (step_q < StW'(NumProd)) begin
        prod_q[step_q[IdxW-1:0]] <= prod_c;
      end else begin
        m01_q <= mat_t'(prod_q[3])  - mat_t'(prod_q[4]);
        m02_q <= mat_t'(prod_q[5])  + mat_t'(prod_q[6]);
        m11_q <= mat_t'(prod_q[8])  + mat_t'(prod_q[9]);
        m12_q <= mat_t'(prod_q[10]) - mat_t'(prod_q[11]);
      end
    end
  end

  always_comb begin
    mat_o[0][0] = mat_t'(prod_q[2]);
    mat_o[0][1] = m01_q;
    mat_o[0][2] = m02_q;
    mat_o[1][0] = mat_t'(prod_q[7]);
    mat_o[1][1] = m11_q;
    mat_o[1][2] = m12_q;
    mat_o[2][0] = -mat_t'(s2);
    mat_o[2][1] = mat_t'(prod_q[12]);
    mat_o[2][2] = mat_t'(prod_q[13]);
  end

  assign done_o = done_q;

endmodule

// ----- design/edr_row_lane.sv -----
// ----------------------------------------------------------------------------
// edr_row_lane
// One earth axis: dot product of a matrix row with the body velocity, then
// the saturated earth velocity and the position accumulator of that axis.
// ----------------------------------------------------------------------------
module edr_row_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  edr_pkg::mat_row_t            row_i,
  input  edr_pkg::vel_vec_t            vel_i,
  input  logic [edr_pkg::DtW-1:0]      dt_i,
  output logic                         done_o,
  output edr_pkg::vel_t                ev_o,
  output edr_pkg::pos_t                pos_o
);
  import edr_pkg::*;

  localparam int unsigned MulW = MatW + VelW;
  localparam int unsigned AccW = MulW + 2;
  localparam int unsigned PmW  = VelW + DtW + 1;
  localparam logic signed [AccW-1:0] AccHalf = AccW'(32768);
  localparam logic signed [PmW-1:0]  PmHalf  = PmW'(32768);
  localparam vel_t VelMax = vel_t'({1'b0, {(VelW-1){1'b1}}});
  localparam vel_t VelMin = vel_t'({1'b1, {(VelW-1){1'b0}}});
  localparam pos_t PosMax = pos_t'({1'b0, {(PosW-1){1'b1}}});
  localparam pos_t PosMin = pos_t'({1'b1, {(PosW-1){1'b0}}});

  // Sequence steps.
  localparam logic [2:0] StepTerm0 = 3'd0;
  localparam logic [2:0] StepTerm1 = 3'd1;
  localparam logic [2:0] StepTerm2 = 3'd2;
  localparam logic [2:0] StepRound = 3'd3;
  localparam logic [2:0] StepPos   = 3'd4;

  logic                   busy_q;
  logic                   done_q;
  logic [2:0]             cnt_q;
  logic signed [AccW-1:0] acc_q;
  vel_t                   ev_q;
  pos_t                   pos_q;

  mat_t                   op_m;
  vel_t                   op_v;
  logic signed [MulW-1:0] mul_c;
  logic signed [AccW-1:0] evr_c;
  logic [AccW-VelW:0]     ev_hi;
  vel_t                   ev_sat_c;
  logic signed [PmW-1:0]  pmul_c;
  logic signed [PmW-1:0]  prnd_c;
  logic signed [PosW+1:0] psum_c;
  logic [2:0]             pos_hi;
  pos_t                   pos_sat_c;

  // Term of the dot product for this step.
  always_comb begin
    unique case (cnt_q)
      StepTerm0: begin op_m = row_i[0]; op_v = vel_i[0]; end
      StepTerm1: begin op_m = row_i[1]; op_v = vel_i[1]; end
      StepTerm2: begin op_m = row_i[2]; op_v = vel_i[2]; end
      default:   begin op_m = '0;       op_v = '0;       end
    endcase
    mul_c = $signed(op_m) * $signed(op_v);
  end

  // Earth velocity: round and saturate the dot product.
  always_comb begin
    evr_c = (acc_q + AccHalf) >>> 16;
    ev_hi = evr_c[AccW-1:VelW-1];
    if ((&ev_hi) || !(|ev_hi)) begin
      ev_sat_c = evr_c[VelW-1:0];
    end else if (evr_c[AccW-1]) begin
      ev_sat_c = VelMin;
    end else begin
      ev_sat_c = VelMax;
    end
  end

  // Position step: earth velocity times step time, saturated sum.
  always_comb begin
    pmul_c = ev_q * $signed({1'b0, dt_i});
    prnd_c = (pmul_c + PmHalf) >>> 16;
    psum_c = (PosW + 2)'(pos_q) + (PosW + 2)'(prnd_c);
    pos_hi = psum_c[PosW+1:PosW-1];
    if ((&pos_hi) || !(|pos_hi)) begin
      pos_sat_c = psum_c[PosW-1:0];
    end else if (psum_c[PosW+1]) begin
      pos_sat_c = PosMin;
    end else begin
      pos_sat_c = PosMax;
    end
  end

  // Sequencer and position state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= StepTerm0;
      pos_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StepTerm0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == StepPos) begin
          pos_q  <= pos_sat_c;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Accumulator and earth velocity.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == StepRound) begin
        ev_q <= ev_sat_c;
      end else if (cnt_q != StepPos) begin
        acc_q <= acc_q + AccW'(mul_c);
      end
    end
  end

  assign done_o = done_q;
  assign ev_o   = ev_q;
  assign pos_o  = pos_q;

endmodule

// ----- design/euler_dcm_dead_reckoning_step.sv -----
// ----------------------------------------------------------------------------
// euler_dcm_dead_reckoning_step
// Strapdown dead-reckoning step: integrates body acceleration, rotates the
// velocity into the earth frame with an Euler-angle DCM and integrates it.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An accepted input beat goes through the three
// angle lanes (phase multiply, phase rounding, two ROM reads and the handoff),
// the matrix builder, whose single shared multiplier forms the fourteen matrix
// products one per cycle before the sums and the handoff, the three row lanes
// (three dot-product terms, rounding, position update and the handoff) and
// the load of the output register. The next input beat is taken on the cycle
// after the result is loaded, even while that result still waits in the output
// register, so a new beat is never taken while an item is in flight. A result
// that is still waiting when the next one is ready stalls the block until it
// is taken. step_time (Q0.16 seconds, reset 0.1 s) is written through
// cfg_we_i/cfg_data_i and must only change while no item is in flight.
// Velocity and position accumulators saturate and are cleared by reset.
// ----------------------------------------------------------------------------
`include "euler_dcm_dead_reckoning_step_macros.svh"

module euler_dcm_dead_reckoning_step #(
  parameter int unsigned SINE_TABLE_ENTRIES = edr_pkg::SineEntriesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [edr_pkg::DtW-1:0] cfg_data_i,
  edr_in_if.sink                  in_i,
  edr_out_if.source               out_o
);
  import edr_pkg::*;

  localparam int unsigned VmW = AcclW + DtW + 1;
  localparam logic signed [VmW-1:0] VmHalf = VmW'(128);
  localparam vel_t VelMax = vel_t'({1'b0, {(VelW-1){1'b1}}});
  localparam vel_t VelMin = vel_t'({1'b1, {(VelW-1){1'b0}}});

  edr_state_e state_q, state_d;

  logic [DtW-1:0] step_time_q;
  vel_vec_t       vel_q;
  vel_vec_t       vel_d;
  logic           out_valid_q;
  out_beat_t      out_q;

  logic in_accept;
  logic trig_start;
  logic dcm_start;
  logic row_start;
  logic out_load;
  logic out_stall;

  logic signed [AngW-1:0]  ang_c  [3];
  logic signed [AcclW-1:0] accl_c [3];
  logic [2:0]              trig_done_w;
  logic [2:0]              row_done_w;
  logic                    trig_done;
  logic                    row_done;
  logic                    dcm_done;
  sincos_t [2:0]           sc_w;
  mat_row_t [2:0]          mat_w;
  vel_t                    ev_w  [3];
  pos_t                    pos_w [3];

  assign ang_c[0]  = in_i.payload.roll_angle;
  assign ang_c[1]  = in_i.payload.pitch_angle;
  assign ang_c[2]  = in_i.payload.yaw_angle;
  assign accl_c[0] = in_i.payload.accel_x;
  assign accl_c[1] = in_i.payload.accel_y;
  assign accl_c[2] = in_i.payload.accel_z;

  assign in_accept = in_i.valid && in_i.ready;
  assign trig_done = &trig_done_w;
  assign row_done  = &row_done_w;
  assign out_stall = out_valid_q && !out_o.ready;

  // Angle lanes.
  for (genvar i = 0; i < 3; i++) begin : g_trig
    edr_trig_lane #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_trig (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(trig_start),
      .angle_i(ang_c[i]),
      .done_o (trig_done_w[i]),
      .sc_o   (sc_w[i])
    );
  end

  // Matrix builder.
  edr_dcm u_dcm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dcm_start),
    .sc_i   (sc_w),
    .done_o (dcm_done),
    .mat_o  (mat_w)
  );

  // Earth-axis lanes.
  for (genvar i = 0; i < 3; i++) begin : g_row
    edr_row_lane u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(row_start),
      .row_i  (mat_w[i]),
      .vel_i  (vel_q),
      .dt_i   (step_time_q),
      .done_o (row_done_w[i]),
      .ev_o   (ev_w[i]),
      .pos_o  (pos_w[i])
    );
  end

  // Body velocity update from the accepted beat.
  always_comb begin
    logic signed [VmW-1:0]  vmul;
    logic signed [VmW-1:0]  vrnd;
    logic signed [VelW+1:0] vsum;
    logic [2:0]             vhi;
    for (int i = 0; i < 3; i++) begin
      vmul = accl_c[i] * $signed({1'b0, step_time_q});
      vrnd = (vmul + VmHalf) >>> 8;
      vsum = (VelW + 2)'($signed(vel_q[i])) + (VelW + 2)'(vrnd);
      vhi  = vsum[VelW+1:VelW-1];
      if ((&vhi) || !(|vhi)) begin
        vel_d[i] = vsum[VelW-1:0];
      end else if (vsum[VelW+1]) begin
        vel_d[i] = VelMin;
      end else begin
        vel_d[i] = VelMax;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_TRIG;
      ST_TRIG: if (trig_done) state_d = ST_DCM;
      ST_DCM:  if (dcm_done) state_d = ST_ROWS;
      ST_ROWS: if (row_done) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequence.
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    trig_start = in_accept;
    dcm_start  = (state_q == ST_TRIG) && trig_done;
    row_start  = (state_q == ST_DCM) && dcm_done;
    out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_time_q <= StepTimeReset;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        step_time_q <= cfg_data_i;
      end
      if (in_accept) begin
        vel_q <= vel_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.earth_vel_x <= ev_w[0];
      out_q.earth_vel_y <= ev_w[1];
      out_q.earth_vel_z <= ev_w[2];
      out_q.pos_x       <= pos_w[0];
      out_q.pos_y       <= pos_w[1];
      out_q.pos_z       <= pos_w[2];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Checks on the sequence.
  `EDR_ASSERT_NEXT(a_trig_to_dcm, (state_q == ST_TRIG) && trig_done, state_q == ST_DCM)
  `EDR_ASSERT_NEXT(a_out_wait, (state_q == ST_DONE) && out_stall, (state_q == ST_DONE) && out_valid_q)
  `EDR_ASSERT_NEXT(a_vel_hold, !in_accept, $stable(vel_q))
  `EDR_ASSERT_IMPL(a_rows_together, row_done_w[0], &row_done_w)

endmodule

// ----- tb/sv/edr_step_checker.sv -----
// ----------------------------------------------------------------------------
// edr_step_checker
// Watches the sample and result channels and the step-time register port.
// Computes the expected earth velocity and position for every accepted sample
// beat and compares each result beat with the oldest expectation.
// ----------------------------------------------------------------------------
module edr_step_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  edr_in_if           in_mon,
  edr_out_if          out_mon,
  output int          pending_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import edr_pkg::*;

  localparam longint Entries = SineEntriesDef;

  // Quarter-wave sine in Q16, entries 0..Entries.
  longint    quarter_q16 [0:SineEntriesDef];
  // Predictor state.
  longint    dt_q16;
  longint    vel_body [3];
  longint    pos_acc [3];
  out_beat_t expected_q [$];

  assign pending_o = expected_q.size();

  // Rounding shift: floor((x + 2^(n-1)) / 2^n).
  function automatic longint round_shift(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Taylor series of sin to x^15 in Q30, rounded to Q16.
  function automatic longint taylor_q16(longint unsigned k);
    longint unsigned ph;
    longint unsigned ph2;
    longint unsigned term;
    longint          acc;
    longint          r;
    ph   = (k * PiHalfQ30 + longint'(Entries / 2)) / longint'(Entries);
    ph2  = (ph * ph) >> 30;
    term = ph;
    acc  = longint'(ph);
    for (int i = 1; i <= 7; i++) begin
      term = ((term * ph2) >> 30) / longint'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = round_shift(acc, 14);
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic longint wave_at(longint unsigned ph);
    longint unsigned quad;
    longint unsigned rem;
    ph   = ph % (4 * Entries);
    quad = ph / Entries;
    rem  = ph % Entries;
    case (quad)
      0: return quarter_q16[rem];
      1: return quarter_q16[Entries - rem];
      2: return -quarter_q16[rem];
      default: return -quarter_q16[Entries - rem];
    endcase
  endfunction

  // Sine is odd in the angle, cosine even; the phase wraps at a full turn.
  function automatic void angle_trig(longint ang, output longint s, output longint c);
    longint unsigned mag;
    longint unsigned ph;
    mag = (ang < 0) ? -ang : ang;
    ph  = ((mag * InvTwoPiQ32 * (4 * Entries) + (64'd1 << 44)) >> 45) % (4 * Entries);
    s   = wave_at(ph);
    if (ang < 0) begin
      s = -s;
    end
    c = wave_at(ph + Entries);
  endfunction

  function automatic longint prod2(longint a, longint b);
    return round_shift(a * b, 16);
  endfunction

  function automatic longint prod3(longint a, longint b, longint c);
    return round_shift(round_shift(a * b, 16) * c, 16);
  endfunction

  // Advances the state by one sample and returns the expected result.
  function automatic out_beat_t dead_reckon(in_beat_t smp);
    longint    s1, c1, s2, c2, s3, c3;
    longint    dcm [3][3];
    longint    ev [3];
    longint    accel [3];
    longint    dot;
    out_beat_t res;
    angle_trig(longint'(smp.roll_angle), s1, c1);
    angle_trig(longint'(smp.pitch_angle), s2, c2);
    angle_trig(longint'(smp.yaw_angle), s3, c3);
    accel[0] = smp.accel_x;
    accel[1] = smp.accel_y;
    accel[2] = smp.accel_z;
    for (int i = 0; i < 3; i++) begin
      vel_body[i] = clamp(vel_body[i] + round_shift(accel[i] * dt_q16, 8),
                          -64'sd2147483648, 64'sd2147483647);
    end
    dcm[0][0] = prod2(c2, c3);
    dcm[0][1] = prod3(s1, s2, c3) - prod2(c1, s3);
    dcm[0][2] = prod3(c1, s2, c3) + prod2(s1, s3);
    dcm[1][0] = prod2(c2, s3);
    dcm[1][1] = prod3(s1, s2, s3) + prod2(c1, c3);
    dcm[1][2] = prod3(c1, s2, s3) - prod2(s1, c3);
    dcm[2][0] = -s2;
    dcm[2][1] = prod2(s1, c2);
    dcm[2][2] = prod2(c1, c2);
    for (int i = 0; i < 3; i++) begin
      dot = dcm[i][0] * vel_body[0] + dcm[i][1] * vel_body[1] + dcm[i][2] * vel_body[2];
      ev[i] = clamp(round_shift(dot, 16), -64'sd2147483648, 64'sd2147483647);
      pos_acc[i] = clamp(pos_acc[i] + round_shift(ev[i] * dt_q16, 16),
                         -64'sd140737488355328, 64'sd140737488355327);
    end
    res.earth_vel_x = vel_t'(ev[0]);
    res.earth_vel_y = vel_t'(ev[1]);
    res.earth_vel_z = vel_t'(ev[2]);
    res.pos_x       = pos_t'(pos_acc[0]);
    res.pos_y       = pos_t'(pos_acc[1]);
    res.pos_z       = pos_t'(pos_acc[2]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    for (int k = 0; k <= SineEntriesDef; k++) begin
      quarter_q16[k] = taylor_q16(k);
    end
  end

  // Sampled at the falling edge: all inputs change only at rising edges.
  always @(negedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      dt_q16 = StepTimeReset;
      for (int i = 0; i < 3; i++) begin
        vel_body[i] = 0;
        pos_acc[i]  = 0;
      end
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        dt_q16 = cfg_data_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(dead_reckon(in_mon.payload));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t result beat with no sample waiting", $realtime);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.payload.earth_vel_x !== want.earth_vel_x)
            report_mismatch("earth_vel_x", out_mon.payload.earth_vel_x, want.earth_vel_x);
          if (out_mon.payload.earth_vel_y !== want.earth_vel_y)
            report_mismatch("earth_vel_y", out_mon.payload.earth_vel_y, want.earth_vel_y);
          if (out_mon.payload.earth_vel_z !== want.earth_vel_z)
            report_mismatch("earth_vel_z", out_mon.payload.earth_vel_z, want.earth_vel_z);
          if (out_mon.payload.pos_x !== want.pos_x)
            report_mismatch("pos_x", out_mon.payload.pos_x, want.pos_x);
          if (out_mon.payload.pos_y !== want.pos_y)
            report_mismatch("pos_y", out_mon.payload.pos_y, want.pos_y);
          if (out_mon.payload.pos_z !== want.pos_z)
            report_mismatch("pos_z", out_mon.payload.pos_z, want.pos_z);
        end
      end
    end
  end

endmodule

// ----- tb/sv/euler_dcm_dead_reckoning_step_tb.sv -----
// ----------------------------------------------------------------------------
// euler_dcm_dead_reckoning_step_tb
// Drives sample beats with random gaps and random result back-pressure,
// changes the step time between phases while the block is idle, and leaves
// all prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module euler_dcm_dead_reckoning_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import edr_pkg::*;

  localparam int DrainCycles = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_data;
  int          pending;
  int          fail_count;
  bit          no_idle;

  edr_in_if  smp_ch ();
  edr_out_if res_ch ();

  euler_dcm_dead_reckoning_step i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (smp_ch),
    .out_o      (res_ch)
  );

  edr_step_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_mon       (smp_ch),
    .out_mon      (res_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, none during quiet stretches.
  function automatic int idle_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  // Sends one sample beat and returns at the edge that accepts it.
  task automatic send_sample(in_beat_t smp);
    int gap;
    bit taken;
    gap = idle_len();
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_ch.valid   <= 1'b1;
    smp_ch.payload <= smp;
    do begin
      @(negedge clk_i);
      taken = smp_ch.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Waits for every result and a quiet tail, then writes the step time.
  task automatic set_step_time(logic [15:0] dt);
    smp_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= dt;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 7)) - 16'd3;
      1: return 16'h8000 + 16'($urandom_range(0, 3));
      2: return 16'h7FFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_beat_t random_sample(bit push_hard);
    in_beat_t smp;
    smp.roll_angle  = pick_angle();
    smp.pitch_angle = pick_angle();
    smp.yaw_angle   = pick_angle();
    smp.accel_x     = 16'($urandom);
    smp.accel_y     = 16'($urandom);
    smp.accel_z     = 16'($urandom);
    // Near-full-scale acceleration of a fixed sign per axis drives the velocity into saturation.
    if (push_hard) begin
      smp.accel_x = 16'sh7F00 + 16'($urandom_range(0, 255));
      smp.accel_y = 16'sh8000 + 16'($urandom_range(0, 255));
      smp.accel_z = 16'sh7F00 + 16'($urandom_range(0, 255));
    end
    return smp;
  endfunction

  // Result back-pressure: random stalls with quiet stretches.
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = idle_len();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic signed [15:0] ang_set [8];
    logic [15:0]        dt_set [6];
    in_beat_t           smp;
    ang_set = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd12868, -16'sd12868,
                16'sd25736, 16'sd1, -16'sd1};
    dt_set  = '{16'hFFFF, 16'd1, 16'd0, 16'd6554, 16'd0, 16'd0};
    no_idle        = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    smp_ch.valid   = 1'b0;
    smp_ch.payload = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset step time: angle extremes and quadrant
    // boundaries, and full-scale accelerations of both signs.
    for (int k = 0; k < 8; k++) begin
      smp.roll_angle  = ang_set[k];
      smp.pitch_angle = ang_set[(k + 3) % 8];
      smp.yaw_angle   = ang_set[(k + 5) % 8];
      smp.accel_x     = (k % 2) ? 16'sh7FFF : 16'sh8000;
      smp.accel_y     = (k % 3) ? 16'sh8000 : 16'sh7FFF;
      smp.accel_z     = 16'(k * 4099);
      send_sample(smp);
    end
    for (int k = 0; k < 8; k++) begin
      smp.roll_angle  = ang_set[(k + 1) % 8];
      smp.pitch_angle = ang_set[k];
      smp.yaw_angle   = ang_set[(k + 6) % 8];
      smp.accel_x     = '0;
      smp.accel_y     = 16'sh0100;
      smp.accel_z     = -16'sh0100;
      send_sample(smp);
    end

    // Random phases over several step times; the largest step time phase
    // saturates the velocity, and zero step time holds the state.
    dt_set[4] = 16'($urandom_range(2, 65534));
    dt_set[5] = 16'($urandom_range(2, 65534));
    for (int ph = 0; ph < 6; ph++) begin
      set_step_time(dt_set[ph]);
      for (int n = 0; n < 272; n++) begin
        if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_sample(random_sample(ph == 0 && n >= 8));
      end
      no_idle = 1'b0;
    end
    smp_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
